// ===== hdl/aqic_pkg.sv =====
// ----------------------------------------------------------------------------
// aqic_pkg
// Types, breakpoint tables and reciprocal constants for the AQI core.
// ----------------------------------------------------------------------------
package aqic_pkg;

   localparam int CONC_W      = 16;
   localparam int INDEX_W     = 10;
   localparam int TENTHS_W    = 20;
   localparam int DIFF_W      = 12;
   localparam int RISE_W      = 9;
   localparam int QUOT_W      = 9;
   localparam int NUM_W       = DIFF_W + RISE_W;
   localparam int RECIP_W     = 26;
   localparam int RECIP_SHIFT = 32;
   localparam int PRODUCT_W   = NUM_W + RECIP_W;
   localparam int BP_COUNT    = 7;
   localparam int SEG_COUNT   = BP_COUNT - 1;
   localparam int SEG_IDX_W   = 3;

   localparam logic [INDEX_W-1:0] INDEX_MAX = 10'd1000;

   // breakpoints in tenths of ug/m3
   localparam logic [TENTHS_W-1:0] FINE_BP [BP_COUNT] =
      '{20'd0, 20'd121, 20'd355, 20'd555, 20'd1505, 20'd2505, 20'd5000};
   localparam logic [TENTHS_W-1:0] COARSE_BP [BP_COUNT] =
      '{20'd0, 20'd550, 20'd1550, 20'd2550, 20'd3550, 20'd4250, 20'd6040};

   // segment start value and rise, both in hundredths (twice the AQI)
   localparam logic [INDEX_W-1:0] SEG_BASE [SEG_COUNT] =
      '{10'd0, 10'd100, 10'd200, 10'd300, 10'd400, 10'd600};
   localparam logic [RISE_W-1:0] SEG_RISE [SEG_COUNT] =
      '{9'd100, 9'd100, 9'd100, 9'd100, 9'd200, 9'd400};

   // ceil(2^32 / span); exact floor division for numerators below 2^20
   localparam logic [63:0] RECIP_NUM = 64'd1 << RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] FINE_RECIP [SEG_COUNT] = '{
      RECIP_W'((RECIP_NUM + 64'd120) / 64'd121),
      RECIP_W'((RECIP_NUM + 64'd233) / 64'd234),
      RECIP_W'((RECIP_NUM + 64'd199) / 64'd200),
      RECIP_W'((RECIP_NUM + 64'd949) / 64'd950),
      RECIP_W'((RECIP_NUM + 64'd999) / 64'd1000),
      RECIP_W'((RECIP_NUM + 64'd2494) / 64'd2495)};
   localparam logic [RECIP_W-1:0] COARSE_RECIP [SEG_COUNT] = '{
      RECIP_W'((RECIP_NUM + 64'd549) / 64'd550),
      RECIP_W'((RECIP_NUM + 64'd999) / 64'd1000),
      RECIP_W'((RECIP_NUM + 64'd999) / 64'd1000),
      RECIP_W'((RECIP_NUM + 64'd999) / 64'd1000),
      RECIP_W'((RECIP_NUM + 64'd699) / 64'd700),
      RECIP_W'((RECIP_NUM + 64'd1789) / 64'd1790)};

   typedef struct packed {
      logic [CONC_W-1:0] pm25_conc;
      logic [CONC_W-1:0] pm10_conc;
   } aqic_req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] combined_index;
      logic [INDEX_W-1:0] fine_index;
      logic [INDEX_W-1:0] coarse_index;
      logic               fine_over_range;
      logic               coarse_over_range;
   } aqic_rsp_type;

   typedef struct packed {
      logic               over;
      logic [INDEX_W-1:0] base;
      logic [RISE_W-1:0]  rise;
      logic [DIFF_W-1:0]  diff;
      logic [RECIP_W-1:0] recip;
   } aqic_seg_type;

   typedef struct packed {
      logic               over;
      logic [INDEX_W-1:0] base;
      logic [QUOT_W-1:0]  quot;
   } aqic_quot_type;

endpackage

// ===== hdl/air_quality_index_calculator_core.sv =====
// ----------------------------------------------------------------------------
// air_quality_index_calculator_core
// PM2.5 / PM10 sub-indices by piecewise linear interpolation, 0..10 scale
// in hundredths, with saturation and over-range flags, and their maximum.
//
//   channel    ports                          handshake
//   request    req_data                       start, taken when !busy
//   response   rsp_data                       rsp_strobe, one cycle
//
// One request per cycle while not busy; each taken request passes through the
// segment select, multiply, reciprocal multiply and combine registers.
// busy is high only during reset. Synchronous reset clears the valid
// pipeline; data registers are not reset. Responses cannot be stalled.
// ----------------------------------------------------------------------------
module air_quality_index_calculator_core import aqic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  aqic_req_type req_data,
   output logic         rsp_strobe,
   output aqic_rsp_type rsp_data
);

   logic          req_valid;
   logic          seg_valid;
   aqic_seg_type  seg_fine, seg_coarse;
   logic          num_valid_ff;
   logic          quot_valid_ff;
   aqic_quot_type quot_fine, quot_coarse;
   logic          strobe_ff;
   aqic_rsp_type  rsp_ff, rsp_in;

   assign busy      = reset;
   assign req_valid = start && !busy;

   aqic_segment u_segment (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req_data),
      .seg_valid  (seg_valid),
      .seg_fine   (seg_fine),
      .seg_coarse (seg_coarse)
   );

   aqic_divide u_divide_fine (
      .clock     (clock),
      .load_num  (seg_valid),
      .load_quot (num_valid_ff),
      .seg       (seg_fine),
      .quot      (quot_fine)
   );

   aqic_divide u_divide_coarse (
      .clock     (clock),
      .load_num  (seg_valid),
      .load_quot (num_valid_ff),
      .seg       (seg_coarse),
      .quot      (quot_coarse)
   );

   always_comb begin
      rsp_in.fine_over_range   = quot_fine.over;
      rsp_in.coarse_over_range = quot_coarse.over;
      rsp_in.fine_index   = quot_fine.over ? INDEX_MAX
                          : quot_fine.base + INDEX_W'(quot_fine.quot);
      rsp_in.coarse_index = quot_coarse.over ? INDEX_MAX
                          : quot_coarse.base + INDEX_W'(quot_coarse.quot);
      rsp_in.combined_index = (rsp_in.fine_index > rsp_in.coarse_index)
                            ? rsp_in.fine_index : rsp_in.coarse_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff  <= 1'b0;
         quot_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         num_valid_ff  <= seg_valid;
         quot_valid_ff <= num_valid_ff;
         strobe_ff     <= quot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (quot_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== hdl/aqic_segment.sv =====
// ----------------------------------------------------------------------------
// aqic_segment
// Stage 1: scales both concentrations to tenths, picks the breakpoint
// segment, and registers offset into the segment plus its constants.
// ----------------------------------------------------------------------------
module aqic_segment import aqic_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  aqic_req_type req,
   output logic         seg_valid,
   output aqic_seg_type seg_fine,
   output aqic_seg_type seg_coarse
);

   logic         valid_ff;
   aqic_seg_type fine_ff, fine_in;
   aqic_seg_type coarse_ff, coarse_in;

   function automatic aqic_seg_type seg_lookup(input logic [CONC_W-1:0] conc,
                                               input logic coarse);
      logic [TENTHS_W-1:0]  c10;
      logic [TENTHS_W-1:0]  bp [BP_COUNT];
      logic [SEG_IDX_W-1:0] idx;
      aqic_seg_type         s;
      for (int i = 0; i < BP_COUNT; i++) begin
         bp[i] = coarse ? COARSE_BP[i] : FINE_BP[i];
      end
      c10 = TENTHS_W'({conc, 3'b000}) + TENTHS_W'({conc, 1'b0});
      // breakpoints rise, so the last one passed names the segment
      idx = '0;
      for (int i = 1; i < BP_COUNT - 1; i++) begin
         if (c10 >= bp[i]) begin
            idx = SEG_IDX_W'(i);
         end
      end
      s.over  = (c10 >= bp[BP_COUNT-1]);
      s.diff  = DIFF_W'(c10 - bp[idx]);
      s.rise  = SEG_RISE[idx];
      s.base  = SEG_BASE[idx];
      s.recip = coarse ? COARSE_RECIP[idx] : FINE_RECIP[idx];
      return s;
   endfunction

   always_comb begin
      fine_in   = seg_lookup(req.pm25_conc, 1'b0);
      coarse_in = seg_lookup(req.pm10_conc, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid) begin
         fine_ff   <= fine_in;
         coarse_ff <= coarse_in;
      end
   end

   assign seg_valid  = valid_ff;
   assign seg_fine   = fine_ff;
   assign seg_coarse = coarse_ff;

endmodule

// ===== hdl/aqic_divide.sv =====
// ----------------------------------------------------------------------------
// aqic_divide
// Stages 2 and 3 of one lane: rise * offset, then division by the segment
// span as a multiply by its reciprocal.
// ----------------------------------------------------------------------------
module aqic_divide import aqic_pkg::*; (
   input  logic          clock,
   input  logic          load_num,
   input  logic          load_quot,
   input  aqic_seg_type  seg,
   output aqic_quot_type quot
);

   logic [NUM_W-1:0]     num_ff, num_in;
   logic [RECIP_W-1:0]   recip_ff;
   logic [INDEX_W-1:0]   base_ff;
   logic                 over_ff;
   logic [PRODUCT_W-1:0] product;
   aqic_quot_type        quot_ff, quot_in;

   assign num_in  = NUM_W'(seg.rise) * NUM_W'(seg.diff);
   assign product = PRODUCT_W'(num_ff) * PRODUCT_W'(recip_ff);

   always_comb begin
      quot_in.over = over_ff;
      quot_in.base = base_ff;
      quot_in.quot = product[RECIP_SHIFT +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (load_num) begin
         num_ff   <= num_in;
         recip_ff <= seg.recip;
         base_ff  <= seg.base;
         over_ff  <= seg.over;
      end
      if (load_quot) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

// ===== hdl/aqic_checker.sv =====
// ----------------------------------------------------------------------------
// aqic_checker
// Port-level checks on the AQI core: latency, saturation and maximum.
// ----------------------------------------------------------------------------
module aqic_checker import aqic_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input aqic_rsp_type rsp_data
);

   // every taken request is answered by a response strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("response missing four cycles after request");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("response without matching request");

   a_combined_max: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.combined_index >= rsp_data.fine_index) &&
                     (rsp_data.combined_index >= rsp_data.coarse_index) &&
                     ((rsp_data.combined_index == rsp_data.fine_index) ||
                      (rsp_data.combined_index == rsp_data.coarse_index)))
      else $error("combined index is not the larger sub-index");

   a_fine_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.fine_over_range) |-> rsp_data.fine_index == INDEX_MAX)
      else $error("fine over range without saturation");

   a_coarse_saturate: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.coarse_over_range) |->
         rsp_data.coarse_index == INDEX_MAX)
      else $error("coarse over range without saturation");

endmodule

bind air_quality_index_calculator_core aqic_checker u_aqic_checker (.*);

// ===== tb/tb_air_quality_index_calculator_core.sv =====
// ----------------------------------------------------------------------------
// tb_air_quality_index_calculator_core
// Self-checking bench for the AQI core. Drives directed edge and over-range
// requests, then PM2.5 / PM10 requests in random bursts. Each accepted request
// is scored against a behavioral interpolator over the breakpoint tables. Every
// response must match the oldest pending prediction field by field.
// ----------------------------------------------------------------------------
module tb_air_quality_index_calculator_core import aqic_pkg::*;;

   localparam int RANDOM_COUNT = 2000;
   localparam int DRAIN_CYCLES = 12;

   // breakpoints in tenths of ug/m3, AQI end points shared by both tables
   localparam int unsigned PM25_TENTHS [7] = '{0, 121, 355, 555, 1505, 2505, 5000};
   localparam int unsigned PM10_TENTHS [7] = '{0, 550, 1550, 2550, 3550, 4250, 6040};
   localparam int unsigned AQI_POINTS  [7] = '{0, 50, 100, 150, 200, 300, 500};

   // whole-ug values next to each upper breakpoint
   localparam int unsigned PM25_EDGES [6] = '{12, 35, 55, 150, 250, 500};
   localparam int unsigned PM10_EDGES [6] = '{55, 155, 255, 355, 425, 604};

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   aqic_req_type req_data;
   logic         rsp_strobe;
   aqic_rsp_type rsp_data;

   aqic_rsp_type expected_indices [$];
   aqic_rsp_type oldest_index;
   int           mismatches;

   air_quality_index_calculator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // one pollutant's sub-index in hundredths of the 0..10 scale
   function automatic void calc_sub_index(input logic [15:0] conc, input bit coarse,
                                          output logic [9:0] index, output logic over);
      int unsigned bp [7];
      int unsigned c10;
      int unsigned seg;
      int unsigned value;
      if (coarse) begin
         bp = PM10_TENTHS;
      end else begin
         bp = PM25_TENTHS;
      end
      c10 = int'(conc) * 10;
      if (c10 >= bp[6]) begin
         over  = 1'b1;
         index = INDEX_MAX;
         return;
      end
      over = 1'b0;
      seg  = 1;
      while (seg < 6 && c10 >= bp[seg])
         seg++;
      value = 2 * AQI_POINTS[seg-1]
            + (2 * (AQI_POINTS[seg] - AQI_POINTS[seg-1]) * (c10 - bp[seg-1]))
              / (bp[seg] - bp[seg-1]);
      if (value > 1000)
         value = 1000;
      index = 10'(value);
   endfunction

   function automatic aqic_rsp_type calc_air_quality(input aqic_req_type sample);
      aqic_rsp_type r;
      calc_sub_index(sample.pm25_conc, 1'b0, r.fine_index, r.fine_over_range);
      calc_sub_index(sample.pm10_conc, 1'b1, r.coarse_index, r.coarse_over_range);
      r.combined_index = (r.fine_index > r.coarse_index) ? r.fine_index : r.coarse_index;
      return r;
   endfunction

   // holds start high until the request is taken; called at a rising edge
   task automatic send_sample(input logic [15:0] pm25, input logic [15:0] pm10);
      aqic_req_type sample;
      sample.pm25_conc = pm25;
      sample.pm10_conc = pm10;
      start    <= 1'b1;
      req_data <= sample;
      do @(posedge clock); while (busy !== 1'b0);
      expected_indices.push_back(calc_air_quality(sample));
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_indices.size() == 0) begin
            $error("response with no pending request: %p", rsp_data);
            mismatches++;
         end else begin
            oldest_index = expected_indices.pop_front();
            if (rsp_data.combined_index !== oldest_index.combined_index) begin
               $error("combined_index: expected %0d, got %0d",
                      oldest_index.combined_index, rsp_data.combined_index);
               mismatches++;
            end
            if (rsp_data.fine_index !== oldest_index.fine_index) begin
               $error("fine_index: expected %0d, got %0d",
                      oldest_index.fine_index, rsp_data.fine_index);
               mismatches++;
            end
            if (rsp_data.coarse_index !== oldest_index.coarse_index) begin
               $error("coarse_index: expected %0d, got %0d",
                      oldest_index.coarse_index, rsp_data.coarse_index);
               mismatches++;
            end
            if (rsp_data.fine_over_range !== oldest_index.fine_over_range) begin
               $error("fine_over_range: expected %0b, got %0b",
                      oldest_index.fine_over_range, rsp_data.fine_over_range);
               mismatches++;
            end
            if (rsp_data.coarse_over_range !== oldest_index.coarse_over_range) begin
               $error("coarse_over_range: expected %0b, got %0b",
                      oldest_index.coarse_over_range, rsp_data.coarse_over_range);
               mismatches++;
            end
         end
      end
   end

   // zero, one, the top bit of the field and the inner segment edges of both tables
   task automatic test_segment_edges();
      send_sample(16'd0, 16'd0);
      send_sample(16'd1, 16'd1);
      for (int i = 0; i < 5; i++) begin
         // PM10 lands just below, then exactly on, its inner breakpoints here
         send_sample(16'(PM25_EDGES[i]), 16'(PM10_EDGES[i] - 1));
         send_sample(16'(PM25_EDGES[i] + 1), 16'(PM10_EDGES[i]));
      end
      idle_sender(3);
      send_sample(16'd32768, 16'd1000);
   endtask

   // saturation below, at and beyond the top breakpoints, each pollutant alone and both
   task automatic test_over_range();
      send_sample(16'd499, 16'd603);
      send_sample(16'd500, 16'd604);
      send_sample(16'hFFFF, 16'd0);
      send_sample(16'd0, 16'hFFFF);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'd501, 16'd100);
      send_sample(16'd40, 16'd605);
   endtask

   function automatic logic [15:0] pick_conc(input bit coarse);
      int unsigned kind;
      int unsigned edge_val;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         return 16'($urandom_range(0, coarse ? 640 : 530));
      end else if (kind < 8) begin
         edge_val = coarse ? PM10_EDGES[$urandom_range(0, 5)]
                           : PM25_EDGES[$urandom_range(0, 5)];
         return 16'(edge_val + $urandom_range(0, 2) - 1);
      end
      return 16'($urandom);
   endfunction

   task automatic test_random_readings(input int count);
      int burst_left;
      burst_left = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            // some bursts run back to back with no gap at all
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7));
            burst_left = $urandom_range(1, 40);
         end
         send_sample(pick_conc(1'b0), pick_conc(1'b1));
         burst_left--;
      end
   endtask

   initial begin
      mismatches = 0;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_segment_edges();
      test_over_range();
      test_random_readings(RANDOM_COUNT);

      start <= 1'b0;
      while (expected_indices.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
